// File: hdl/wlsq_pkg.sv
package wlsq_pkg;

  localparam int unsigned GainW = 26;
  localparam int unsigned AccW  = 48;

  // Q2.24 gains, rounded to nearest
  localparam logic signed [GainW-1:0] GVx = 26'sd29663562;
  localparam logic signed [GainW-1:0] GWx = 26'sd1112384;
  localparam logic signed [GainW-1:0] GVy = 26'sd29455244;
  localparam logic signed [GainW-1:0] GWy = 26'sd1104572;
  localparam logic signed [GainW-1:0] GWz = 26'sd1472762;
  localparam logic signed [GainW-1:0] GVz = 26'sd16131938;

  localparam logic [15:0] VMaxRst  = 16'd51610;
  localparam logic [11:0] DvMaxRst = 12'd205;

  localparam logic RegVMax  = 1'b0;
  localparam logic RegDvMax = 1'b1;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMac  = 6'b000010,
    StUpd  = 6'b000100,
    StDiv  = 6'b001000,
    StNext = 6'b010000,
    StOut  = 6'b100000
  } state_e;

  typedef struct packed {
    logic       start;
    logic [4:0] dividend;
  } div_ctl_t;

endpackage

// File: hdl/wlsq_div.sv
// Restoring divider, one quotient bit per cycle: q = num / den.
module wlsq_div #(
  parameter int unsigned NumW = 29
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [15:0]     den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [16:0]     rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [16:0]     trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[15:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_i}) begin
        rem_d = trial - {1'b0, den_i};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quo_o  = quo_d;
endmodule

// File: hdl/weighted_lsq_motor_mixer.sv
// Four-motor weighted least-squares mixer. A transfer on the command channel
// carries six signed Q4.12 axis values; after computation one transfer on the
// result channel carries four PWM counts and the four updated Q4.12 voltages.
// Work is done by one shared 16x26 multiplier (six products, three
// accumulators) and one bit-serial divider for the PWM scaling, under a small
// sequencer: an item takes the multiply steps, then per motor an update step,
// a divide and a step to the next motor, then an output step. The block holds
// stall high while busy and while a result waits. The user must write v_max
// and dv_max through the config port only while idle; the block itself does
// not enforce it. A v_max of zero gives zero PWM counts.
module weighted_lsq_motor_mixer #(
  parameter int unsigned PWM_BITS  = 13,
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  vel_x_i,
  input  logic signed [15:0]  vel_y_i,
  input  logic signed [15:0]  vel_z_i,
  input  logic signed [15:0]  rate_x_i,
  input  logic signed [15:0]  rate_y_i,
  input  logic signed [15:0]  rate_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PWM_BITS-1:0] pwm_0_o,
  output logic [PWM_BITS-1:0] pwm_1_o,
  output logic [PWM_BITS-1:0] pwm_2_o,
  output logic [PWM_BITS-1:0] pwm_3_o,
  output logic [15:0]         volt_0_o,
  output logic [15:0]         volt_1_o,
  output logic [15:0]         volt_2_o,
  output logic [15:0]         volt_3_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import wlsq_pkg::*;

  localparam int unsigned NumW = 16 + PWM_BITS;

  // Reset defaults: 12.6 V and 0.05 V in the FRAC_BITS scale, rounded
  localparam longint unsigned VMaxRaw  = (126 * (64'd1 << FRAC_BITS) + 5) / 10;
  localparam longint unsigned DvMaxRaw = (5 * (64'd1 << FRAC_BITS) + 50) / 100;
  localparam logic [15:0] VMaxInit  = (VMaxRaw > 64'd65535) ? 16'hFFFF : 16'(VMaxRaw);
  localparam logic [11:0] DvMaxInit = (DvMaxRaw > 64'd4095) ? 12'hFFF : 12'(DvMaxRaw);

  state_e state_q, state_d;
  logic [15:0] vmax_q;
  logic [11:0] dvmax_q;
  logic [15:0] volts_q [4];
  logic [PWM_BITS-1:0] pwm_q [4];
  logic signed [15:0] in_q [6];
  logic signed [AccW-1:0] c1_q, c2_q, c3_q;
  logic [2:0] step_q;
  logic [1:0] mot_q;
  logic       out_valid_q;

  logic signed [15:0]    mul_a;
  logic signed [GainW-1:0] mul_b;
  logic signed [AccW-1:0]  prod;

  // Shared multiplier: one input times one gain per cycle.
  always_comb begin
    mul_a = in_q[step_q];
    unique case (step_q)
      3'd0:    mul_b = GVx;
      3'd1:    mul_b = -GWx;
      3'd2:    mul_b = GVy;
      3'd3:    mul_b = -GWy;
      3'd4:    mul_b = GWz;
      default: mul_b = GVz;
    endcase
    prod = AccW'(mul_a) * AccW'(mul_b);
  end

  // Per-motor update
  logic signed [AccW-1:0] acc, rb;
  logic signed [AccW-1:0] dv;
  logic signed [18:0]     vsum;
  logic [15:0]            vnew;
  logic signed [AccW-1:0] lim;

  always_comb begin
    acc = -c3_q;
    if (mot_q == 2'd0 || mot_q == 2'd3) acc = acc - c1_q; else acc = acc + c1_q;
    if (mot_q == 2'd1 || mot_q == 2'd3) acc = acc - c2_q; else acc = acc + c2_q;
    rb  = acc + AccW'(64'sd8388608);
    dv  = rb >>> 24;
    lim = AccW'({1'b0, dvmax_q});
    if (dv > lim) dv = lim;
    if (dv < -lim) dv = -lim;
    vsum = 19'(signed'({3'b0, volts_q[mot_q]})) + 19'(dv);
    if (vsum < 0) vnew = '0;
    else if (vsum > 19'(signed'({3'b0, vmax_q}))) vnew = vmax_q;
    else vnew = vsum[15:0];
  end

  // PWM divide: v*(2^P-1)/v_max, started on the freshly updated voltage
  logic            div_start, div_done;
  logic [NumW-1:0] div_num, div_quo;
  logic [15:0]     vcur;
  assign vcur    = vnew;
  assign div_num = NumW'({vcur, {PWM_BITS{1'b0}}}) - NumW'(vcur);
  assign div_start = (state_q == StUpd);

  wlsq_div #(.NumW(NumW)) u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (vmax_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != StIdle) || out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc) state_d = StMac;
      StMac:  if (step_q == 3'd5) state_d = StUpd;
      StUpd:  state_d = StDiv;
      StDiv:  if (div_done) state_d = StNext;
      StNext: state_d = (mot_q == 2'd3) ? StOut : StUpd;
      StOut:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      vmax_q      <= VMaxInit;
      dvmax_q     <= DvMaxInit;
      step_q      <= '0;
      mot_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) volts_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegVMax:  vmax_q  <= cfg_data_i;
          RegDvMax: dvmax_q <= cfg_data_i[11:0];
          default:  ;
        endcase
      end
      if (out_acc) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          step_q <= '0;
          mot_q  <= '0;
        end
        StMac:  step_q <= step_q + 3'd1;
        StUpd:  volts_q[mot_q] <= vnew;
        StNext: mot_q <= mot_q + 2'd1;
        StOut:  out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q[0] <= vel_x_i;
      in_q[1] <= rate_x_i;
      in_q[2] <= vel_y_i;
      in_q[3] <= rate_y_i;
      in_q[4] <= rate_z_i;
      in_q[5] <= vel_z_i;
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
    end else if (state_q == StMac) begin
      if (step_q < 3'd2) c1_q <= c1_q + prod;
      else if (step_q < 3'd5) c2_q <= c2_q + prod;
      else c3_q <= c3_q + prod;
    end
    if (div_done) begin
      pwm_q[mot_q] <= (vmax_q == 16'd0) ? '0 : div_quo[PWM_BITS-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign pwm_0_o  = pwm_q[0];
  assign pwm_1_o  = pwm_q[1];
  assign pwm_2_o  = pwm_q[2];
  assign pwm_3_o  = pwm_q[3];
  assign volt_0_o = volts_q[0];
  assign volt_1_o = volts_q[1];
  assign volt_2_o = volts_q[2];
  assign volt_3_o = volts_q[3];

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_acc) else $error("accept while busy");
  a_out_after_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StOut)) else $error("stray result");
  a_volt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == StUpd) |-> (volts_q[$past(mot_q)] <= $past(vmax_q)))
    else $error("voltage above v_max");
`endif
endmodule
